>>> design/alb_pkg.sv
package alb_pkg;

	localparam int unsigned FRAME_SIZE_DEF = 128;
	localparam logic [15:0] IDLE_LIMIT_RST = 16'd250;

	localparam logic [2:0] REQ_PUT    = 3'd0;
	localparam logic [2:0] REQ_BACK   = 3'd1;
	localparam logic [2:0] REQ_COMMIT = 3'd2;
	localparam logic [2:0] REQ_TICK   = 3'd3;
	localparam logic [2:0] REQ_READ   = 3'd4;

	typedef struct packed {
		logic       we;
		logic [7:0] waddr;
		logic [7:0] wdata;
		logic [7:0] raddr;
	} alb_mem_req_t;

endpackage

>>> design/alb_mem.sv
module alb_mem #(
	parameter int unsigned FRAME_SIZE = alb_pkg::FRAME_SIZE_DEF
) (
	input  logic                  clk,
	input  alb_pkg::alb_mem_req_t mem_req,
	output logic [7:0]            rdata
);
	import alb_pkg::*;

	localparam int unsigned AW = (FRAME_SIZE > 1) ? $clog2(FRAME_SIZE) : 1;

	logic [7:0] store_q [FRAME_SIZE];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			store_q[mem_req.waddr[AW-1:0]] <= mem_req.wdata;
		end
		rdata_q <= store_q[mem_req.raddr[AW-1:0]];
	end

	assign rdata = rdata_q;

endmodule

>>> design/alb_ctrl.sv
module alb_ctrl #(
	parameter int unsigned FRAME_SIZE = alb_pkg::FRAME_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2:0]            req_type,
	input  logic [7:0]            char_code,
	input  logic [7:0]            read_index,
	input  logic                  cfg_valid,
	input  logic [15:0]           cfg_idle_limit,
	input  logic [7:0]            rdata,
	output logic                  busy,
	output alb_pkg::alb_mem_req_t mem_req,
	output logic                  done,
	output logic [7:0]            read_data,
	output logic [7:0]            fill_level,
	output logic                  frame_committed
);
	import alb_pkg::*;

	localparam int unsigned AW = (FRAME_SIZE > 1) ? $clog2(FRAME_SIZE) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_SIZE - 1);
	localparam logic [7:0] FS8 = 8'(FRAME_SIZE);

	typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_READ} state_t;

	state_t        state_q;
	logic [AW-1:0] ptr_q;
	logic [7:0]    wp_q;
	logic [15:0]   idle_q;
	logic [15:0]   limit_q;
	logic          report_q;
	logic          in_range_q;
	logic          done_q;
	logic [7:0]    rd_q;
	logic          committed_q;

	logic        accept;
	logic        full;
	logic [16:0] idle_next;
	logic        timeout;
	logic        go_commit;

	assign accept    = start && (state_q == ST_IDLE);
	assign full      = (wp_q == FS8);
	assign idle_next = {1'b0, idle_q} + 17'd1;
	assign timeout   = idle_next >= {1'b0, limit_q};
	assign go_commit = accept && ((req_type == REQ_COMMIT) ||
		((req_type == REQ_TICK) && (wp_q != 8'd0) && timeout));

	always_comb begin
		mem_req       = '0;
		mem_req.raddr = read_index;
		if (state_q == ST_SWEEP) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = 8'(ptr_q);
		end else if (accept) begin
			if ((req_type == REQ_PUT) && !full) begin
				mem_req.we    = 1'b1;
				mem_req.waddr = wp_q;
				mem_req.wdata = char_code;
			end else if ((req_type == REQ_BACK) && (wp_q != 8'd0)) begin
				mem_req.we    = 1'b1;
				mem_req.waddr = wp_q - 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// power-up clearing pass walks the whole frame
			state_q     <= ST_SWEEP;
			ptr_q       <= '0;
			wp_q        <= '0;
			idle_q      <= '0;
			limit_q     <= IDLE_LIMIT_RST;
			report_q    <= 1'b0;
			in_range_q  <= 1'b0;
			done_q      <= 1'b0;
			rd_q        <= '0;
			committed_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				limit_q <= cfg_idle_limit;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_q        <= '0;
						committed_q <= 1'b0;
						if (go_commit) begin
							if (full) begin
								// nothing left to clear
								wp_q        <= '0;
								idle_q      <= '0;
								committed_q <= 1'b1;
								done_q      <= 1'b1;
							end else begin
								ptr_q    <= wp_q[AW-1:0];
								report_q <= 1'b1;
								state_q  <= ST_SWEEP;
							end
						end else begin
							case (req_type)
								REQ_PUT: begin
									if (!full) begin
										wp_q   <= wp_q + 8'd1;
										idle_q <= '0;
									end
									done_q <= 1'b1;
								end
								REQ_BACK: begin
									if (wp_q != 8'd0) begin
										wp_q   <= wp_q - 8'd1;
										idle_q <= '0;
									end
									done_q <= 1'b1;
								end
								REQ_TICK: begin
									if (wp_q == 8'd0) begin
										idle_q <= '0;
									end else begin
										idle_q <= idle_next[15:0];
									end
									done_q <= 1'b1;
								end
								REQ_READ: begin
									in_range_q <= read_index < FS8;
									state_q    <= ST_READ;
								end
								default: begin
									done_q <= 1'b1;
								end
							endcase
						end
					end
				end
				ST_SWEEP: begin
					if (ptr_q == LAST_IDX) begin
						state_q  <= ST_IDLE;
						wp_q     <= '0;
						idle_q   <= '0;
						report_q <= 1'b0;
						if (report_q) begin
							committed_q <= 1'b1;
							done_q      <= 1'b1;
						end
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				ST_READ: begin
					rd_q    <= in_range_q ? rdata : 8'd0;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign done            = done_q;
	assign read_data       = rd_q;
	assign fill_level      = wp_q;
	assign frame_committed = committed_q;

endmodule

>>> design/ascii_line_buffer_idle_commit.sv
// Channel   Handshake             Payload
// request   start / busy          req_type, char_code, read_index
// result    done (one cycle)      read_data, fill_level, frame_committed
// config    cfg_valid / cfg_ready cfg_idle_limit
//
// Put, backspace, tick and unknown requests: result in the cycle after accept.
// Read: passes through ST_READ for the registered read port of the frame memory.
// Commit (explicit or on timeout): the sweep clears the entries from fill_level
// to the end of the frame, one entry cleared per cycle through the single memory
// write port; a full frame skips the sweep. After reset a clearing pass over the
// whole frame keeps busy high. cfg_ready is always high; the receiver cannot stall.
module ascii_line_buffer_idle_commit #(
	parameter int unsigned FRAME_SIZE = alb_pkg::FRAME_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [7:0]  char_code,
	input  logic [7:0]  read_index,
	output logic        done,
	output logic [7:0]  read_data,
	output logic [7:0]  fill_level,
	output logic        frame_committed,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_idle_limit
);
	import alb_pkg::*;

	alb_mem_req_t mem_req;
	logic [7:0]   rdata;

	assign cfg_ready = 1'b1;

	alb_ctrl #(
		.FRAME_SIZE(FRAME_SIZE)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.req_type       (req_type),
		.char_code      (char_code),
		.read_index     (read_index),
		.cfg_valid      (cfg_valid),
		.cfg_idle_limit (cfg_idle_limit),
		.rdata          (rdata),
		.busy           (busy),
		.mem_req        (mem_req),
		.done           (done),
		.read_data      (read_data),
		.fill_level     (fill_level),
		.frame_committed(frame_committed)
	);

	alb_mem #(
		.FRAME_SIZE(FRAME_SIZE)
	) u_mem (
		.clk    (clk),
		.mem_req(mem_req),
		.rdata  (rdata)
	);

endmodule

>>> tb/tb_ascii_line_buffer_idle_commit.sv
module tb_ascii_line_buffer_idle_commit;
	timeunit 1ns;
	timeprecision 1ps;

	import alb_pkg::*;

	localparam int unsigned FRAME_SIZE = FRAME_SIZE_DEF;
	localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] ch;
		logic [7:0] idx;
	} frame_req_t;

	typedef struct packed {
		logic [7:0] data;
		logic [7:0] fill;
		logic       committed;
	} frame_result_t;

	class frame_scoreboard;
		logic [7:0]    store [FRAME_SIZE];
		int unsigned   pos;
		logic [15:0]   idle_ticks;
		logic [15:0]   limit;
		frame_result_t awaited [$];
		int unsigned   mismatches;

		function new();
			foreach (store[i]) store[i] = '0;
			pos = 0;
			idle_ticks = '0;
			limit = IDLE_LIMIT_RST;
			mismatches = 0;
		endfunction

		function void set_idle_limit(logic [15:0] value);
			limit = value;
		endfunction

		// clear the tail from the write position on, keep the rest
		function void flush_frame();
			for (int unsigned i = pos; i < FRAME_SIZE; i++)
				store[i] = '0;
			pos = 0;
			idle_ticks = '0;
		endfunction

		function void note_request(frame_req_t r);
			frame_result_t res;
			int unsigned   next_cnt;
			res = '0;
			case (r.kind)
				REQ_PUT: begin
					if (pos < FRAME_SIZE) begin
						store[pos] = r.ch;
						pos++;
						idle_ticks = '0;
					end
				end
				REQ_BACK: begin
					if (pos > 0) begin
						pos--;
						store[pos] = '0;
						idle_ticks = '0;
					end
				end
				REQ_COMMIT: begin
					flush_frame();
					res.committed = 1'b1;
				end
				REQ_TICK: begin
					if (pos == 0) begin
						idle_ticks = '0;
					end else begin
						next_cnt = int'(idle_ticks) + 1;
						if (next_cnt >= int'(limit)) begin
							flush_frame();
							res.committed = 1'b1;
						end else begin
							idle_ticks = next_cnt[15:0];
						end
					end
				end
				REQ_READ: begin
					if (r.idx < FRAME_SIZE)
						res.data = store[r.idx];
				end
				default: ;
			endcase
			res.fill = pos[7:0];
			awaited.push_back(res);
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: %s", msg);
		endfunction

		function void check_result(frame_result_t got);
			frame_result_t want;
			if (awaited.size() == 0) begin
				flag($sformatf("result with nothing pending (read_data %0h fill_level %0d)",
					got.data, got.fill));
				return;
			end
			want = awaited.pop_front();
			if (got.data !== want.data)
				flag($sformatf("read_data expected %0h got %0h", want.data, got.data));
			if (got.fill !== want.fill)
				flag($sformatf("fill_level expected %0d got %0d", want.fill, got.fill));
			if (got.committed !== want.committed)
				flag($sformatf("frame_committed expected %0b got %0b",
					want.committed, got.committed));
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  req_type = '0;
	logic [7:0]  char_code = '0;
	logic [7:0]  read_index = '0;
	logic        done;
	logic [7:0]  read_data;
	logic [7:0]  fill_level;
	logic        frame_committed;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_idle_limit = '0;

	frame_scoreboard sb = new();
	bit              quiet_run = 1'b0;

	ascii_line_buffer_idle_commit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.char_code      (char_code),
		.read_index     (read_index),
		.done           (done),
		.read_data      (read_data),
		.fill_level     (fill_level),
		.frame_committed(frame_committed),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_idle_limit (cfg_idle_limit)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result({read_data, fill_level, frame_committed});
	end

	task automatic send_req(input logic [2:0] kind, input logic [7:0] ch,
		input logic [7:0] idx);
		int unsigned gap;
		frame_req_t  r;
		r = '{kind: kind, ch: ch, idx: idx};
		gap = quiet_run ? 0 : $urandom_range(0, 7);
		if ($urandom_range(0, 39) == 0)
			quiet_run = !quiet_run;
		// with no gap, hold start high straight into the next word
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= kind;
		char_code <= ch;
		read_index <= idx;
		do @(posedge clk); while (busy);
		sb.note_request(r);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_idle_limit(input logic [15:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_idle_limit <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_idle_limit(value);
	endtask

	function automatic logic [7:0] rand_index();
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, FRAME_SIZE - 1));
	endfunction

	task automatic run_mix(input int unsigned count, input int unsigned tick_pct);
		int unsigned pick;
		logic [2:0]  kind;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				kind = REQ_PUT;
			else if (pick < 50)
				kind = REQ_BACK;
			else if (pick < 54)
				kind = REQ_COMMIT;
			else if (pick < 54 + tick_pct)
				kind = REQ_TICK;
			else if (pick < 95)
				kind = REQ_READ;
			else
				kind = 3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
			send_req(kind, 8'($urandom_range(0, 255)), rand_index());
		end
	endtask

	// short typed words followed by idle time, so timeouts actually fire
	task automatic type_then_idle(input int unsigned bursts, input int unsigned ticks);
		repeat (bursts) begin
			repeat ($urandom_range(1, 6))
				send_req(REQ_PUT, 8'($urandom_range(0, 255)), rand_index());
			if ($urandom_range(0, 2) == 0)
				send_req(REQ_BACK, 8'($urandom_range(0, 255)), rand_index());
			send_req(REQ_READ, 8'($urandom_range(0, 255)), rand_index());
			repeat (ticks)
				send_req(REQ_TICK, 8'($urandom_range(0, 255)), rand_index());
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		drain();

		send_req(REQ_READ, 8'h00, 8'h00);
		send_req(REQ_TICK, 8'h00, 8'h00);
		send_req(REQ_BACK, 8'h00, 8'h00);
		send_req(REQ_COMMIT, 8'h00, 8'h00);
		send_req(REQ_PUT, 8'hFF, 8'h00);
		send_req(REQ_PUT, 8'h00, 8'hFF);
		send_req(REQ_PUT, 8'h55, 8'h00);
		send_req(REQ_READ, 8'h00, 8'h00);
		send_req(REQ_READ, 8'h00, 8'h02);
		send_req(REQ_READ, 8'h00, 8'(FRAME_SIZE - 1));
		send_req(REQ_READ, 8'h00, 8'(FRAME_SIZE));
		send_req(REQ_READ, 8'hFF, 8'hFF);
		send_req(REQ_BACK, 8'hAA, 8'h00);
		send_req(REQ_READ, 8'h00, 8'h02);
		send_req(REQ_TICK, 8'h00, 8'h00);
		send_req(REQ_UNUSED_FIRST, 8'hFF, 8'hFF);
		send_req(REQ_UNUSED_LAST, 8'h00, 8'h00);
		send_req(REQ_COMMIT, 8'h00, 8'h00);
		send_req(REQ_READ, 8'h00, 8'h00);
		send_req(REQ_READ, 8'h00, 8'h01);
		send_req(REQ_READ, 8'h00, 8'h02);

		// zero limit: first tick on a non-empty frame commits
		write_idle_limit(16'd0);
		type_then_idle(3, 1);
		run_mix(40, 20);

		write_idle_limit(16'd1);
		run_mix(50, 20);

		write_idle_limit(16'd3);
		type_then_idle(15, 4);
		run_mix(60, 30);

		// widest limit: fill past the end so extra puts are dropped
		write_idle_limit(16'hFFFF);
		repeat (FRAME_SIZE + 4)
			send_req(REQ_PUT, 8'($urandom_range(0, 255)), rand_index());
		repeat (6)
			send_req(REQ_READ, 8'($urandom_range(0, 255)), rand_index());
		send_req(REQ_TICK, 8'($urandom_range(0, 255)), rand_index());
		send_req(REQ_COMMIT, 8'($urandom_range(0, 255)), rand_index());
		run_mix(40, 10);

		write_idle_limit(16'd7);
		type_then_idle(8, 8);
		run_mix(40, 25);

		write_idle_limit(IDLE_LIMIT_RST);
		run_mix(60, 10);

		drain();
		repeat (FRAME_SIZE + 12) @(posedge clk);
		if (sb.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end
endmodule

>>> sim.f
design/alb_pkg.sv
design/alb_mem.sv
design/alb_ctrl.sv
design/ascii_line_buffer_idle_commit.sv
tb/tb_ascii_line_buffer_idle_commit.sv
